/* src/speq_pkg.sv */
// Types and codes shared by the stable priority event queue.
// No dependencies; imported by speq_cell and the top level.
package speq_pkg;

	// Field widths of one stored event.
	localparam int unsigned PrioW   = 8;
	localparam int unsigned IdW     = 4;
	localparam int unsigned StatW   = 8;
	localparam int unsigned AmtW    = 16;
	localparam int unsigned OccW    = 5;

	// Request modes.
	typedef enum logic {
		MODE_PUSH = 1'b0,
		MODE_POP  = 1'b1
	} speq_mode_t;

	// Result outcome codes.
	typedef enum logic [1:0] {
		OUT_PUSHED    = 2'd0,
		OUT_POPPED    = 2'd1,
		OUT_EMPTY     = 2'd2,
		OUT_DROP_FULL = 2'd3
	} speq_outcome_t;

	// One stored event.
	typedef struct packed {
		logic [PrioW-1:0]       prio;
		logic [IdW-1:0]         sys;
		logic [IdW-1:0]         res;
		logic [StatW-1:0]       stat;
		logic signed [AmtW-1:0] amt;
	} speq_entry_t;

	// Request word.
	typedef struct packed {
		logic                   mode;
		logic [PrioW-1:0]       priority_req;
		logic [IdW-1:0]         system_id;
		logic [IdW-1:0]         resource_id;
		logic [StatW-1:0]       status_code;
		logic signed [AmtW-1:0] amount;
	} speq_req_t;

	// Response word.
	typedef struct packed {
		logic [1:0]             outcome;
		logic [PrioW-1:0]       out_priority;
		logic [IdW-1:0]         out_system_id;
		logic [IdW-1:0]         out_resource_id;
		logic [StatW-1:0]       out_status_code;
		logic signed [AmtW-1:0] out_amount;
		logic [OccW-1:0]        occupancy;
	} speq_rsp_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic        push;
		logic        pop;
		speq_entry_t ent;
	} speq_cmd_t;

endpackage

/* src/speq_cell.sv */
// One cell of the sorted event chain: holds a single event and shifts it
// to or from its neighbours. Depends on speq_pkg.
module speq_cell
	import speq_pkg::*;
(
	input  logic        clk,
	input  speq_cmd_t   cmd,
	input  logic        occupied,
	input  speq_entry_t left_ent,
	input  logic        left_keeps,
	input  speq_entry_t right_ent,
	output speq_entry_t ent,
	output logic        keeps
);

	speq_entry_t ent_q;

	// A stored event of equal or higher priority stays where it is on a push.
	assign keeps = occupied && (ent_q.prio >= cmd.ent.prio);
	assign ent   = ent_q;

	// On a push the first cell that does not keep takes the new event, the
	// cells behind it take their left neighbour; on a pop everything moves left.
	always_ff @(posedge clk) begin
		if (cmd.push && !keeps) begin
			if (left_keeps) begin
				ent_q <= cmd.ent;
			end else begin
				ent_q <= left_ent;
			end
		end else if (cmd.pop) begin
			ent_q <= right_ent;
		end
	end

endmodule

/* src/stable_priority_event_queue_unit.sv */
// Top level of the stable priority event queue: a chain of speq_cell
// instances, the occupancy counter and the response register. Depends on speq_pkg.
//
//  channel | direction | handshake            | word
//  req     | in        | req_valid/req_ready  | req_word (speq_req_t)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_word (speq_rsp_t)
//
// For every request word all cells compare their priority with the pushed one
// in parallel and shift together, so a new word can be
// accepted each cycle while the response register is free or being emptied.
// Reset clears the occupancy count and the response valid; cell contents are
// not reset. When the response is stalled, req_ready falls and the chain holds.
module stable_priority_event_queue_unit
	import speq_pkg::*;
#(
	parameter int unsigned CAPACITY = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  speq_req_t req_word,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output speq_rsp_t rsp_word
);

	localparam int unsigned CntW = $clog2(CAPACITY + 1);

	logic [CntW-1:0] count_q;
	logic [CntW-1:0] count_next;
	logic            rsp_valid_q;
	speq_rsp_t       rsp_q;
	logic            req_fire;
	logic            is_pop;
	logic            full;
	logic            empty;
	speq_cmd_t       cmd;
	speq_rsp_t       rsp_next;

	speq_entry_t     cell_ent   [CAPACITY];
	logic            cell_keeps [CAPACITY];

	// Handshake: accept while the response register is free or draining.
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign req_fire  = req_valid && req_ready;
	assign is_pop    = (req_word.mode == MODE_POP);
	assign full      = (count_q == CntW'(CAPACITY));
	assign empty     = (count_q == '0);

	// Command to the chain.
	always_comb begin
		cmd.push     = req_fire && !is_pop && !full;
		cmd.pop      = req_fire && is_pop && !empty;
		cmd.ent.prio = req_word.priority_req;
		cmd.ent.sys  = req_word.system_id;
		cmd.ent.res  = req_word.resource_id;
		cmd.ent.stat = req_word.status_code;
		cmd.ent.amt  = req_word.amount;
	end

	// The chain of cells, one per entry, the head at index zero.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		speq_entry_t left_ent;
		speq_entry_t right_ent;
		logic        left_keeps;

		if (i == 0) begin : g_head
			assign left_ent   = '0;
			assign left_keeps = 1'b1;
		end else begin : g_body
			assign left_ent   = cell_ent[i-1];
			assign left_keeps = cell_keeps[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_ent = '0;
		end else begin : g_inner
			assign right_ent = cell_ent[i+1];
		end

		speq_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occupied   (count_q > CntW'(i)),
			.left_ent   (left_ent),
			.left_keeps (left_keeps),
			.right_ent  (right_ent),
			.ent        (cell_ent[i]),
			.keeps      (cell_keeps[i])
		);
	end

	// Occupancy after this word.
	always_comb begin
		count_next = count_q;
		if (cmd.push) begin
			count_next = count_q + CntW'(1);
		end else if (cmd.pop) begin
			count_next = count_q - CntW'(1);
		end
	end

	// Response word: event fields only on a successful pop.
	always_comb begin
		rsp_next = '0;
		rsp_next.occupancy = OccW'(count_next);
		priority if (is_pop && empty) begin
			rsp_next.outcome = OUT_EMPTY;
		end else if (is_pop) begin
			rsp_next.outcome         = OUT_POPPED;
			rsp_next.out_priority    = cell_ent[0].prio;
			rsp_next.out_system_id   = cell_ent[0].sys;
			rsp_next.out_resource_id = cell_ent[0].res;
			rsp_next.out_status_code = cell_ent[0].stat;
			rsp_next.out_amount      = cell_ent[0].amt;
		end else if (full) begin
			rsp_next.outcome = OUT_DROP_FULL;
		end else begin
			rsp_next.outcome = OUT_PUSHED;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (req_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload register.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	// The count never passes the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(CAPACITY))
		else $error("occupancy count beyond capacity");

	// A pop on a non-empty queue removes exactly one event.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && is_pop && !empty) |=> (count_q == $past(count_q) - CntW'(1)))
		else $error("pop did not decrement occupancy");

	// The two front cells stay in service order.
	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CntW'(2)) |-> (cell_ent[0].prio >= cell_ent[1].prio))
		else $error("head cells out of priority order");

	// A push into a full queue leaves the count unchanged.
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && !is_pop && full) |=> (count_q == $past(count_q)))
		else $error("push into full queue changed occupancy");

endmodule
